>>> design/i2cm_pkg.sv
package i2cm_pkg;

  // Default sizes
  localparam int DEFAULT_FIFO_DEPTH = 16;
  localparam int DEFAULT_ADDR_BITS  = 7;

  // Field widths fixed by the register map
  localparam int WORD_W = 32;
  localparam int LEN_W  = 16;
  localparam int CPP_W  = 16;
  localparam int THR_W  = 15;
  localparam int ACC_W  = 17;

  typedef logic [1:0]        func_t;
  typedef logic [2:0]        reg_idx_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CPP_W-1:0]  cpp_t;
  typedef logic [7:0]        byte_t;

  // Item kinds
  localparam func_t FUNC_WRITE = 2'd0;
  localparam func_t FUNC_READ  = 2'd1;
  localparam func_t FUNC_TICK  = 2'd2;

  // Register indexes
  localparam reg_idx_t REG_CTRL   = 3'd0;
  localparam reg_idx_t REG_STATUS = 3'd1;
  localparam reg_idx_t REG_LENGTH = 3'd2;
  localparam reg_idx_t REG_ADDR   = 3'd3;
  localparam reg_idx_t REG_FIFO   = 3'd4;

  // Control and status bit positions
  localparam int CTRL_READ_BIT  = 0;
  localparam int CTRL_CLR_LO    = 4;
  localparam int CTRL_CLR_HI    = 5;
  localparam int CTRL_ST_BIT    = 7;
  localparam int CTRL_EN_BIT    = 15;
  localparam int STAT_DONE_BIT  = 1;

  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Phase budget: reset value and divide-by-three reciprocal (exact for 16-bit operands)
  localparam cpp_t              CPP_RESET  = 16'd300;
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(CPP_RESET / 3);
  localparam logic [CPP_W-1:0]  DIV3_RECIP = 16'd43691;
  localparam int                DIV3_SHIFT = 17;

endpackage

>>> design/i2cm_if.sv
interface i2cm_in_if;
  import i2cm_pkg::*;

  logic     valid;
  logic     ready;
  func_t    func;
  reg_idx_t reg_index;
  word_t    write_data;
  cpp_t     tick_cycles;
  logic     sda_in;

  modport source(output valid, func, reg_index, write_data, tick_cycles, sda_in,
                 input ready);
  modport sink(input valid, func, reg_index, write_data, tick_cycles, sda_in,
               output ready);
endinterface

interface i2cm_out_if #(
  parameter int LVL_W = $clog2(i2cm_pkg::DEFAULT_FIFO_DEPTH + 1)
);
  import i2cm_pkg::*;

  logic             valid;
  logic             ready;
  word_t            read_data;
  logic             sda_out;
  logic             scl_out;
  logic             done_flag;
  logic             busy_res;
  logic [LVL_W-1:0] fifo_level;

  modport source(output valid, read_data, sda_out, scl_out, done_flag, busy_res,
                 fifo_level, input ready);
  modport sink(input valid, read_data, sda_out, scl_out, done_flag, busy_res,
               fifo_level, output ready);
endinterface

>>> design/i2cm_ram.sv
module i2cm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/i2cm_master_bit_engine.sv
// I2C master bit engine. Each input transaction is a register write, a register
// read or a tick of elapsed cycles; each one yields exactly one result transaction
// carrying the read data, the SDA/SCL levels, the done flag, busy and the FIFO level.
// One transaction is taken every clock cycle while input ready is high; its result
// goes to the output register, or to the skid register while the output is stalled,
// and ready drops while the skid is full. The byte FIFO lives in a one-port-write,
// one-port-read RAM: the head byte is held in a register and the RAM read port
// prefetches the entry after the head every cycle, so a pop needs no RAM read wait.
// Configuration (the SCL phase budget) is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce this. A tick
// advances the SCL sequencer once the accumulated cycles reach a third of the budget.
module i2c_master_bit_engine #(
  parameter int FIFO_DEPTH = i2cm_pkg::DEFAULT_FIFO_DEPTH,
  parameter int ADDR_BITS  = i2cm_pkg::DEFAULT_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  i2cm_pkg::cpp_t        cfg_wdata,
  i2cm_in_if.sink               in_ch,
  i2cm_out_if.source            out_ch
);
  import i2cm_pkg::*;

  localparam int IDX_W = $clog2(FIFO_DEPTH);
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W = LVL_W + 1;
  localparam int RES_W = WORD_W + 4 + LVL_W;

  // Bit-level states
  localparam logic [3:0] BS_START = 4'd0;
  localparam logic [3:0] BS_ADDR  = 4'd1;
  localparam logic [3:0] BS_RW    = 4'd2;
  localparam logic [3:0] BS_ACK1  = 4'd3;
  localparam logic [3:0] BS_SEND  = 4'd4;
  localparam logic [3:0] BS_RECV  = 4'd5;
  localparam logic [3:0] BS_ACK2  = 4'd6;
  localparam logic [3:0] BS_MACK  = 4'd7;
  localparam logic [3:0] BS_STOP  = 4'd8;

  // SCL phases
  localparam logic [1:0] PH_UPDATE = 2'd0;
  localparam logic [1:0] PH_HIGH   = 2'd1;
  localparam logic [1:0] PH_LOW    = 2'd2;

  // Register file
  word_t                ctrl_r,  ctrl_nxt;
  word_t                stat_r,  stat_nxt;
  logic [LEN_W-1:0]     len_r,   len_nxt;
  logic [ADDR_BITS-1:0] taddr_r, taddr_nxt;
  word_t                latch_r, latch_nxt;
  logic [THR_W-1:0]     thr_r;

  // FIFO pointers and cached entries
  logic [IDX_W-1:0]     head_r,  head_nxt;
  logic [LVL_W-1:0]     count_r, count_nxt;
  byte_t                front_r, front_nxt;
  logic                 fwd_valid_r;
  byte_t                fwd_data_r;

  // Bit engine
  logic [3:0]           bst_r,   bst_nxt;
  logic [3:0]           cnt_r,   cnt_nxt;
  logic [LEN_W-1:0]     bl_r,    bl_nxt;
  byte_t                rx_r,    rx_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic                 busy_r,  busy_nxt;
  logic                 dir_r,   dir_nxt;
  logic                 sda_r,   sda_nxt;
  logic                 scl_r,   scl_nxt;
  logic [ACC_W-1:0]     acc_r,   acc_nxt;
  logic [ADDR_BITS-1:0] act_r,   act_nxt;

  // Output register and skid
  logic                 out_valid_r, skid_valid_r;
  logic [RES_W-1:0]     out_data_r, skid_data_r, res_nxt;

  // RAM port
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  byte_t                ram_wdata, ram_q, next_byte;

  logic                 accept, take;
  logic                 push_en, pop_en, clear_en;
  byte_t                push_byte;
  word_t                rdata;
  logic [SUM_W-1:0]     tail_sum;
  logic [ACC_W-1:0]     acc_sum;
  logic [3:0]           dec;
  logic [ADDR_BITS-1:0] addr_sh;
  byte_t                front_sh;
  logic [31:0]          thr_prod;

  assign in_ch.ready = rst_n && !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take        = out_valid_r && out_ch.ready;

  // The prefetched entry after the head, or the byte just written there
  assign next_byte = fwd_valid_r ? fwd_data_r : ram_q;
  assign dec       = (cnt_r != 4'd0) ? cnt_r - 4'd1 : 4'd0;
  assign addr_sh   = act_r >> dec;
  assign front_sh  = front_r >> dec[2:0];
  assign acc_sum   = acc_r + ACC_W'(in_ch.tick_cycles);
  assign thr_prod  = 32'(cfg_wdata) * 32'(DIV3_RECIP);

  // Transaction update: register access, FIFO request, and one sequencer step
  always_comb begin
    ctrl_nxt  = ctrl_r;
    stat_nxt  = stat_r;
    len_nxt   = len_r;
    taddr_nxt = taddr_r;
    latch_nxt = latch_r;
    bst_nxt   = bst_r;
    cnt_nxt   = cnt_r;
    bl_nxt    = bl_r;
    rx_nxt    = rx_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    dir_nxt   = dir_r;
    sda_nxt   = sda_r;
    scl_nxt   = scl_r;
    acc_nxt   = acc_r;
    act_nxt   = act_r;
    push_en   = 1'b0;
    push_byte = in_ch.write_data[7:0];
    pop_en    = 1'b0;
    clear_en  = 1'b0;
    rdata     = '0;

    if (accept) begin
      case (in_ch.func)
        FUNC_WRITE: begin
          case (in_ch.reg_index)
            REG_CTRL: begin
              ctrl_nxt = in_ch.write_data;
              clear_en = in_ch.write_data[CTRL_CLR_HI:CTRL_CLR_LO] != 2'b00;
              if (in_ch.write_data[CTRL_EN_BIT] && in_ch.write_data[CTRL_ST_BIT]) begin
                bst_nxt   = BS_START;
                act_nxt   = taddr_r;
                cnt_nxt   = 4'(ADDR_BITS);
                bl_nxt    = len_r;
                dir_nxt   = in_ch.write_data[CTRL_READ_BIT];
                rx_nxt    = '0;
                stat_nxt[STAT_DONE_BIT] = 1'b0;
                sda_nxt   = 1'b1;
                scl_nxt   = 1'b1;
                acc_nxt   = '0;
                busy_nxt  = 1'b1;
                phase_nxt = PH_UPDATE;
              end
            end
            REG_STATUS: stat_nxt  = in_ch.write_data;
            REG_LENGTH: len_nxt   = in_ch.write_data[LEN_W-1:0];
            REG_ADDR:   taddr_nxt = in_ch.write_data[ADDR_BITS-1:0];
            REG_FIFO: begin
              latch_nxt = in_ch.write_data;
              push_en   = 1'b1;
            end
            default: ;
          endcase
        end
        FUNC_READ: begin
          case (in_ch.reg_index)
            REG_CTRL:   rdata = ctrl_r;
            REG_STATUS: rdata = stat_r;
            REG_LENGTH: rdata = WORD_W'(len_r);
            REG_ADDR:   rdata = WORD_W'(taddr_r);
            REG_FIFO: begin
              if (count_r != '0) begin
                latch_nxt = WORD_W'(front_r);
                pop_en    = 1'b1;
              end
              rdata = latch_nxt;
            end
            default: ;
          endcase
        end
        FUNC_TICK: begin
          if (busy_r) begin
            if (acc_sum < ACC_W'(thr_r)) begin
              acc_nxt = acc_sum;
            end else begin
              acc_nxt = '0;
              case (phase_r)
                PH_UPDATE: begin
                  phase_nxt = PH_HIGH;
                  case (bst_r)
                    BS_START: begin
                      sda_nxt = 1'b0;
                      bst_nxt = BS_ADDR;
                    end
                    BS_ADDR: begin
                      cnt_nxt = dec;
                      sda_nxt = addr_sh[0];
                      if (dec == 4'd0) begin
                        bst_nxt = BS_RW;
                      end
                    end
                    BS_RW: begin
                      sda_nxt = dir_r;
                      bst_nxt = BS_ACK1;
                    end
                    BS_ACK1: begin
                      cnt_nxt = BYTE_BITS;
                      bst_nxt = dir_r ? BS_RECV : BS_SEND;
                    end
                    BS_SEND: begin
                      cnt_nxt = dec;
                      sda_nxt = (count_r != '0) ? front_sh[0] : 1'b0;
                      if (dec == 4'd0) begin
                        pop_en  = count_r != '0;
                        bst_nxt = BS_ACK2;
                      end
                    end
                    BS_RECV: begin
                      cnt_nxt = dec;
                      rx_nxt  = rx_r | (byte_t'(in_ch.sda_in) << dec[2:0]);
                      if (dec == 4'd0) begin
                        push_en   = 1'b1;
                        push_byte = rx_nxt;
                        rx_nxt    = '0;
                        bst_nxt   = (bl_r == '0) ? BS_STOP : BS_MACK;
                      end
                    end
                    BS_ACK2: begin
                      bl_nxt = bl_r - 1'b1;
                      if (bl_nxt != '0) begin
                        cnt_nxt = BYTE_BITS;
                        bst_nxt = BS_SEND;
                      end else begin
                        bst_nxt = BS_STOP;
                      end
                    end
                    BS_MACK: begin
                      sda_nxt = 1'b0;
                      if (bl_r != '0) begin
                        bl_nxt  = bl_r - 1'b1;
                        cnt_nxt = BYTE_BITS;
                        bst_nxt = BS_RECV;
                      end else begin
                        bst_nxt = BS_STOP;
                      end
                    end
                    default: begin
                      // Stop bit: release both lines, flag done, drop ST and CLEAR
                      scl_nxt  = 1'b1;
                      sda_nxt  = 1'b1;
                      busy_nxt = 1'b0;
                      stat_nxt[STAT_DONE_BIT] = 1'b1;
                      ctrl_nxt[CTRL_ST_BIT]   = 1'b0;
                      ctrl_nxt[CTRL_CLR_HI:CTRL_CLR_LO] = 2'b00;
                    end
                  endcase
                end
                PH_HIGH: begin
                  scl_nxt   = 1'b1;
                  phase_nxt = PH_LOW;
                end
                default: begin
                  scl_nxt   = 1'b0;
                  phase_nxt = PH_UPDATE;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // FIFO pointers: clear, pop or push (at most one per transaction)
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign ram_waddr = (tail_sum >= SUM_W'(FIFO_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(FIFO_DEPTH)) : IDX_W'(tail_sum);
  assign ram_wdata = push_byte;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    front_nxt = front_r;
    ram_we    = 1'b0;
    if (clear_en) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (pop_en) begin
      head_nxt  = (head_r == IDX_W'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
      front_nxt = next_byte;
    end else if (push_en && count_r != LVL_W'(FIFO_DEPTH)) begin
      ram_we    = 1'b1;
      count_nxt = count_r + 1'b1;
      if (count_r == '0) begin
        front_nxt = push_byte;
      end
    end
  end

  // Prefetch the entry after the new head
  assign ram_raddr = (head_nxt == IDX_W'(FIFO_DEPTH - 1)) ? '0 : head_nxt + 1'b1;

  i2cm_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign res_nxt = {rdata, sda_nxt, scl_nxt, stat_nxt[STAT_DONE_BIT], busy_nxt, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      stat_r      <= '0;
      len_r       <= '0;
      taddr_r     <= '0;
      latch_r     <= '0;
      thr_r       <= THR_RESET;
      head_r      <= '0;
      count_r     <= '0;
      fwd_valid_r <= 1'b0;
      bst_r       <= BS_START;
      cnt_r       <= '0;
      bl_r        <= '0;
      rx_r        <= '0;
      phase_r     <= PH_UPDATE;
      busy_r      <= 1'b0;
      dir_r       <= 1'b0;
      sda_r       <= 1'b1;
      scl_r       <= 1'b1;
      acc_r       <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      ctrl_r      <= ctrl_nxt;
      stat_r      <= stat_nxt;
      len_r       <= len_nxt;
      taddr_r     <= taddr_nxt;
      latch_r     <= latch_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      // Flag a write that hits the address being prefetched
      fwd_valid_r <= ram_we && (ram_waddr == ram_raddr);
      bst_r       <= bst_nxt;
      cnt_r       <= cnt_nxt;
      bl_r        <= bl_nxt;
      rx_r        <= rx_nxt;
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
      dir_r       <= dir_nxt;
      sda_r       <= sda_nxt;
      scl_r       <= scl_nxt;
      acc_r       <= acc_nxt;
      act_r       <= act_nxt;
      if (cfg_we) begin
        thr_r <= thr_prod[DIV3_SHIFT +: THR_W];
      end
      // Output register with one skid entry behind it
      if (skid_valid_r) begin
        if (take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (out_valid_r && !take) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    fwd_data_r <= ram_wdata;
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (accept) begin
      if (out_valid_r && !take) begin
        skid_data_r <= res_nxt;
      end else begin
        out_data_r <= res_nxt;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = out_data_r[RES_W-1 -: WORD_W];
  assign out_ch.sda_out       = out_data_r[LVL_W + 3];
  assign out_ch.scl_out       = out_data_r[LVL_W + 2];
  assign out_ch.done_flag     = out_data_r[LVL_W + 1];
  assign out_ch.busy_res      = out_data_r[LVL_W];
  assign out_ch.fifo_level    = out_data_r[LVL_W-1:0];

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LVL_W'(FIFO_DEPTH))
    else $error("FIFO level beyond depth");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_idle_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> busy_r || $stable(acc_r))
    else $error("cycle accumulator moved while idle");

  a_idle_bus_released: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> scl_r && sda_r)
    else $error("bus lines not released while idle");

endmodule

>>> tb/sv/tb_i2c_master_bit_engine.sv
module tb_i2c_master_bit_engine;
  import i2cm_pkg::*;

  // One bus access as the block takes it, and the status snapshot it answers with.
  typedef struct packed {
    func_t    func;
    reg_idx_t reg_index;
    word_t    write_data;
    cpp_t     tick_cycles;
    logic     sda_in;
  } bus_access_t;

  typedef struct packed {
    word_t      read_data;
    logic       sda;
    logic       scl;
    logic       done;
    logic       busy;
    logic [4:0] level;
  } bus_result_t;

  // Bit-level machine and SCL sequencer states of the predictor.
  typedef enum logic [3:0] {
    BIT_START, BIT_ADDR, BIT_RW, BIT_ACK1, BIT_SEND, BIT_RECV, BIT_ACK2, BIT_MACK, BIT_STOP
  } bit_phase_t;

  typedef enum logic [1:0] {SCL_UPDATE, SCL_HIGH, SCL_LOW} scl_phase_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cpp_t cfg_wdata;

  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();

  i2c_master_bit_engine uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #1 clk = ~clk;

  // Predictor state: a private copy of the register file, FIFO and bus engine.
  cpp_t       m_cpp;
  word_t      m_ctrl;
  word_t      m_stat;
  word_t      m_latch;
  logic [15:0] m_len;
  logic [15:0] m_left;
  logic [6:0] m_taddr;
  logic [6:0] m_addr;
  byte_t      m_fifo [DEFAULT_FIFO_DEPTH];
  int         m_head;
  int         m_count;
  bit_phase_t m_bit;
  logic [3:0] m_bcnt;
  byte_t      m_rx;
  scl_phase_t m_scl_ph;
  logic       m_busy;
  logic       m_dir_rd;
  logic       m_sda;
  logic       m_scl;
  int         m_acc;

  bus_access_t pending_accesses[$];
  bus_result_t pending_bus_results[$];
  bus_access_t on_bus;

  int n_queued   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_fail     = 0;
  int src_gap    = 0;
  int snk_gap    = 0;
  int idle_rate  = 6;
  bit quiet      = 1'b0;
  bit held_long  = 1'b0;

  function automatic void fifo_push_byte(input byte_t b);
    if (m_count < DEFAULT_FIFO_DEPTH) begin
      m_fifo[(m_head + m_count) % DEFAULT_FIFO_DEPTH] = b;
      m_count++;
    end
  endfunction

  function automatic void fifo_pop_byte();
    if (m_count != 0) begin
      m_head = (m_head + 1) % DEFAULT_FIFO_DEPTH;
      m_count--;
    end
  endfunction

  // Apply one accepted access to the predictor and queue the snapshot it yields.
  task automatic predict_bus_step(input bus_access_t a);
    bus_result_t r;
    word_t rdata;
    rdata = '0;
    case (a.func)
      FUNC_WRITE: begin
        case (a.reg_index)
          REG_CTRL: begin
            m_ctrl = a.write_data;
            if (|m_ctrl[CTRL_CLR_HI:CTRL_CLR_LO]) begin
              m_head  = 0;
              m_count = 0;
            end
            // enable together with start (re)launches a transfer from scratch
            if (m_ctrl[CTRL_EN_BIT] && m_ctrl[CTRL_ST_BIT]) begin
              m_bit    = BIT_START;
              m_addr   = m_taddr;
              m_bcnt   = 4'(DEFAULT_ADDR_BITS);
              m_left   = m_len;
              m_dir_rd = m_ctrl[CTRL_READ_BIT];
              m_rx     = '0;
              m_stat[STAT_DONE_BIT] = 1'b0;
              m_sda    = 1'b1;
              m_scl    = 1'b1;
              m_acc    = 0;
              m_busy   = 1'b1;
              m_scl_ph = SCL_UPDATE;
            end
          end
          REG_STATUS: m_stat = a.write_data;
          REG_LENGTH: m_len = a.write_data[15:0];
          REG_ADDR:   m_taddr = a.write_data[6:0];
          REG_FIFO: begin
            m_latch = a.write_data;
            fifo_push_byte(a.write_data[7:0]);
          end
          default: ;
        endcase
      end
      FUNC_READ: begin
        case (a.reg_index)
          REG_CTRL:   rdata = m_ctrl;
          REG_STATUS: rdata = m_stat;
          REG_LENGTH: rdata = {16'b0, m_len};
          REG_ADDR:   rdata = {25'b0, m_taddr};
          REG_FIFO: begin
            // pop into the latch first; an empty FIFO leaves the latch as it was
            if (m_count != 0) begin
              m_latch = {24'b0, m_fifo[m_head]};
              fifo_pop_byte();
            end
            rdata = m_latch;
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        // ticks only count while a transfer runs
        if (m_busy) begin
          m_acc += a.tick_cycles;
          if (m_acc >= m_cpp / 3) begin
            m_acc = 0;
            case (m_scl_ph)
              SCL_UPDATE: begin
                case (m_bit)
                  BIT_START: begin
                    m_sda = 1'b0;
                    m_bit = BIT_ADDR;
                  end
                  BIT_ADDR: begin
                    if (m_bcnt > 0) m_bcnt--;
                    m_sda = m_addr[m_bcnt];
                    if (m_bcnt == 0) m_bit = BIT_RW;
                  end
                  BIT_RW: begin
                    m_sda = m_dir_rd;
                    m_bit = BIT_ACK1;
                  end
                  BIT_ACK1: begin
                    // slave ACK is not sampled
                    m_bcnt = BYTE_BITS;
                    m_bit  = m_dir_rd ? BIT_RECV : BIT_SEND;
                  end
                  BIT_SEND: begin
                    if (m_bcnt > 0) m_bcnt--;
                    m_sda = (m_count != 0) ? m_fifo[m_head][m_bcnt[2:0]] : 1'b0;
                    if (m_bcnt == 0) begin
                      fifo_pop_byte();
                      m_bit = BIT_ACK2;
                    end
                  end
                  BIT_RECV: begin
                    if (m_bcnt > 0) m_bcnt--;
                    if (a.sda_in) m_rx[m_bcnt[2:0]] = 1'b1;
                    if (m_bcnt == 0) begin
                      fifo_push_byte(m_rx);
                      m_rx  = '0;
                      m_bit = (m_left == 0) ? BIT_STOP : BIT_MACK;
                    end
                  end
                  BIT_ACK2: begin
                    m_left = m_left - 16'd1;
                    if (m_left != 0) begin
                      m_bcnt = BYTE_BITS;
                      m_bit  = BIT_SEND;
                    end else begin
                      m_bit = BIT_STOP;
                    end
                  end
                  BIT_MACK: begin
                    m_sda = 1'b0;
                    if (m_left != 0) begin
                      m_left = m_left - 16'd1;
                      m_bcnt = BYTE_BITS;
                      m_bit  = BIT_RECV;
                    end else begin
                      m_bit = BIT_STOP;
                    end
                  end
                  default: begin
                    m_scl  = 1'b1;
                    m_sda  = 1'b1;
                    m_busy = 1'b0;
                    m_stat[STAT_DONE_BIT] = 1'b1;
                    m_ctrl[CTRL_ST_BIT] = 1'b0;
                    m_ctrl[CTRL_CLR_HI:CTRL_CLR_LO] = 2'b00;
                  end
                endcase
                m_scl_ph = SCL_HIGH;
              end
              SCL_HIGH: begin
                m_scl    = 1'b1;
                m_scl_ph = SCL_LOW;
              end
              default: begin
                m_scl    = 1'b0;
                m_scl_ph = SCL_UPDATE;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    r.read_data = rdata;
    r.sda       = m_sda;
    r.scl       = m_scl;
    r.done      = m_stat[STAT_DONE_BIT];
    r.busy      = m_busy;
    r.level     = 5'(m_count);
    pending_bus_results.push_back(r);
  endtask

  // Stimulus builders. The slave's SDA level is random on every access.
  task automatic queue_access(input func_t f, input reg_idx_t r, input word_t d, input cpp_t c);
    bus_access_t a;
    a.func        = f;
    a.reg_index   = r;
    a.write_data  = d;
    a.tick_cycles = c;
    a.sda_in      = 1'($urandom_range(0, 1));
    pending_accesses.push_back(a);
    n_queued++;
  endtask

  // Set up and run one transfer: length, address, send bytes, start, then enough
  // ticks to reach the stop bit (threshold thr). May cut it short when allowed.
  task automatic queue_transfer(input int thr, input bit may_break);
    bit rd;
    int len, nb, goal, got, acc, c;
    word_t ctl;
    rd  = 1'($urandom_range(0, 1));
    len = $urandom_range(1, 3);
    if (rd && $urandom_range(0, 3) == 0) len = 0;
    if (may_break && $urandom_range(0, 15) == 0) len = 0;
    queue_access(FUNC_WRITE, REG_LENGTH, {16'($urandom), 16'(len)}, 16'($urandom));
    queue_access(FUNC_WRITE, REG_ADDR, $urandom, 16'($urandom));
    // load too few, just enough or too many bytes; now and then fill past full
    nb = rd ? 0 : $urandom_range(len > 0 ? len - 1 : 0, len + 1);
    if ($urandom_range(0, 7) == 0) nb = $urandom_range(14, 18);
    repeat (nb) queue_access(FUNC_WRITE, REG_FIFO, $urandom, 16'($urandom));
    ctl = $urandom;
    ctl[CTRL_EN_BIT]   = 1'b1;
    ctl[CTRL_ST_BIT]   = 1'b1;
    ctl[CTRL_READ_BIT] = rd;
    if ($urandom_range(0, 5) != 0) ctl[CTRL_CLR_HI:CTRL_CLR_LO] = 2'b00;
    queue_access(FUNC_WRITE, REG_CTRL, ctl, 16'($urandom));
    // three SCL phases per bit update; the stop needs only its update phase
    goal = rd ? 3 * (18 + 9 * len) + 1 : 3 * (10 + 9 * len) + 1;
    if (may_break && $urandom_range(0, 7) == 0) goal = $urandom_range(1, goal);
    acc = 0;
    got = 0;
    while (got < goal) begin
      if ($urandom_range(0, 11) == 0) begin
        queue_access(FUNC_READ, reg_idx_t'($urandom_range(0, 7)), $urandom, 16'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0:       c = (thr > 0) ? $urandom_range(0, thr - 1) : 0;
          1:       c = $urandom_range(thr, 65535);
          default: c = thr + $urandom_range(0, 2);
        endcase
        queue_access(FUNC_TICK, reg_idx_t'($urandom), $urandom, 16'(c));
        acc += c;
        if (acc >= thr) begin
          got++;
          acc = 0;
        end
      end
    end
    queue_access(FUNC_TICK, reg_idx_t'($urandom), $urandom, 16'($urandom));
    queue_access(FUNC_READ, REG_STATUS, $urandom, 16'($urandom));
    repeat ($urandom_range(0, len + 2)) queue_access(FUNC_READ, REG_FIFO, $urandom, 16'($urandom));
  endtask

  // Mostly transfers with random content, some noise in between; end on a clean
  // transfer so the bus is idle before the next budget change.
  task automatic queue_random_phase(input int n_items, input int thr);
    int stop_at;
    word_t ctl;
    stop_at = n_queued + n_items;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: queue_access(func_t'(3), reg_idx_t'($urandom), $urandom, 16'($urandom));
          1: queue_access(FUNC_WRITE, reg_idx_t'($urandom_range(5, 7)), $urandom, 16'($urandom));
          2: begin
            ctl = $urandom;
            ctl[CTRL_ST_BIT] = 1'b0;
            queue_access(FUNC_WRITE, REG_CTRL, ctl, 16'($urandom));
          end
          default: queue_access(FUNC_WRITE, REG_STATUS, $urandom, 16'($urandom));
        endcase
      end else begin
        queue_transfer(thr, 1'b1);
      end
    end
    queue_transfer(thr, 1'b0);
  endtask

  // Hold until every queued access went in and every result came back.
  task automatic wait_drained();
    while (n_accepted != n_queued || pending_bus_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the phase budget while nothing is in flight.
  task automatic set_phase_budget(input cpp_t v);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    m_cpp = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void note_field(input string what, input word_t want, input word_t got);
    if (got !== want) begin
      n_fail++;
      if (n_fail <= 10)
        $display("result %0d %s: expected %h, got %h", n_results, what, want, got);
    end
  endfunction

  // Driver: present the next access, hold it until accepted, insert random gaps.
  always @(posedge clk) begin : drive_accesses
    logic nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_bus_step(on_bus);
        n_accepted++;
      end
      nv = in_ch.valid && !in_ch.ready;
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_accesses.size() > 0) begin
          on_bus = pending_accesses.pop_front();
          in_ch.func        <= on_bus.func;
          in_ch.reg_index   <= on_bus.reg_index;
          in_ch.write_data  <= on_bus.write_data;
          in_ch.tick_cycles <= on_bus.tick_cycles;
          in_ch.sda_in      <= on_bus.sda_in;
          nv = 1'b1;
          // drop valid for a burst once this one is taken
          if (!quiet && $urandom_range(1, idle_rate) == 1) src_gap = $urandom_range(1, 14);
        end
      end
      in_ch.valid <= nv;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back the block up.
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (!held_long && n_results >= 150) begin
        held_long = 1'b1;
        snk_gap   = 120;
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(1, idle_rate) == 1) begin
        snk_gap = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: compare every accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    bus_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_bus_results.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("result %0d arrived with nothing predicted, read_data %h",
                   n_results, out_ch.read_data);
      end else begin
        want = pending_bus_results.pop_front();
        note_field("read_data", want.read_data, out_ch.read_data);
        note_field("sda_out", 32'(want.sda), 32'(out_ch.sda_out));
        note_field("scl_out", 32'(want.scl), 32'(out_ch.scl_out));
        note_field("done_flag", 32'(want.done), 32'(out_ch.done_flag));
        note_field("busy_res", 32'(want.busy), 32'(out_ch.busy_res));
        note_field("fifo_level", 32'(want.level), 32'(out_ch.fifo_level));
      end
    end
  end

  initial begin : stimulus
    // known levels on every block input from time zero
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_WRITE;
    in_ch.reg_index    = REG_CTRL;
    in_ch.write_data   = '0;
    in_ch.tick_cycles  = '0;
    in_ch.sda_in       = 1'b0;
    out_ch.ready       = 1'b0;

    // predictor starts in the reset state
    m_cpp    = CPP_RESET;
    m_ctrl   = '0;
    m_stat   = '0;
    m_latch  = '0;
    m_len    = '0;
    m_left   = '0;
    m_taddr  = '0;
    m_addr   = '0;
    m_head   = 0;
    m_count  = 0;
    m_bit    = BIT_START;
    m_bcnt   = '0;
    m_rx     = '0;
    m_scl_ph = SCL_UPDATE;
    m_busy   = 1'b0;
    m_dir_rd = 1'b0;
    m_sda    = 1'b1;
    m_scl    = 1'b1;
    m_acc    = 0;

    // directed part at the reset budget: empty pop, unused registers, unknown
    // item kind, idle tick, all-ones and all-zero words, clear, empty-FIFO start
    queue_access(FUNC_READ, REG_FIFO, '0, '0);
    queue_access(FUNC_READ, 3'd7, '1, '1);
    queue_access(FUNC_WRITE, 3'd5, '1, '1);
    queue_access(func_t'(3), 3'd6, '1, '1);
    queue_access(FUNC_TICK, REG_CTRL, '0, 16'hFFFF);
    queue_access(FUNC_WRITE, REG_STATUS, '1, '0);
    queue_access(FUNC_READ, REG_STATUS, '0, '0);
    queue_access(FUNC_WRITE, REG_STATUS, '0, '0);
    queue_access(FUNC_WRITE, REG_LENGTH, 32'hFFFF_0000, '0);
    queue_access(FUNC_READ, REG_LENGTH, '0, '0);
    queue_access(FUNC_WRITE, REG_ADDR, '1, '0);
    queue_access(FUNC_READ, REG_ADDR, '0, '0);
    queue_access(FUNC_WRITE, REG_FIFO, 32'hFFFF_FFA5, '0);
    queue_access(FUNC_WRITE, REG_CTRL, 32'h0000_0030, '0);
    queue_access(FUNC_READ, REG_FIFO, '0, '0);
    queue_access(FUNC_WRITE, REG_FIFO, 32'h0000_005A, '0);
    queue_access(FUNC_READ, REG_FIFO, '0, '0);
    // write start with length zero and an empty FIFO, then ticks of the largest size
    queue_access(FUNC_WRITE, REG_CTRL, 32'h0000_8080, '0);
    repeat (4) queue_access(FUNC_TICK, REG_CTRL, '0, 16'hFFFF);
    queue_access(FUNC_READ, REG_CTRL, '0, '0);
    // all ones: clear plus a restart in the read direction
    queue_access(FUNC_WRITE, REG_CTRL, '1, '0);
    queue_access(FUNC_TICK, REG_CTRL, '0, 16'd100);
    queue_transfer(int'(CPP_RESET) / 3, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // smallest legal budget, the largest, one below three, then 30 and 9
    set_phase_budget(16'd3);
    idle_rate = 6;
    queue_random_phase(60, 1);

    set_phase_budget(16'hFFFF);
    idle_rate = 3;
    queue_random_phase(50, 21845);

    set_phase_budget(16'd2);
    idle_rate = 10;
    queue_random_phase(30, 0);

    set_phase_budget(16'd30);
    idle_rate = 4;
    queue_random_phase(35, 10);

    // last stretch runs back to back on both sides
    set_phase_budget(16'd9);
    quiet = 1'b1;
    queue_random_phase(25, 3);

    wait_drained();
    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
